// ----- hw/rtl/array_table_sort_search_engine_macros.svh -----
// Assertion macros for the array table engine.
`ifndef ARRAY_TABLE_SORT_SEARCH_ENGINE_MACROS_SVH
`define ARRAY_TABLE_SORT_SEARCH_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define ATSE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ATSE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ATSE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ATSE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/atse_pkg.sv -----
// ----------------------------------------------------------------------------
// atse_pkg
// Operation and status codes shared by the array table engine.
// ----------------------------------------------------------------------------
package atse_pkg;
  localparam int unsigned DefCapacity = 16;
  localparam int unsigned DataW = 32;

  typedef enum logic [3:0] {
    OP_CREATE = 4'd0, OP_APPEND = 4'd1, OP_UPDATE = 4'd2, OP_DELETE = 4'd3,
    OP_INSERT = 4'd4, OP_DISPLAY = 4'd5, OP_SORT = 4'd6, OP_FIND = 4'd7,
    OP_SORTFIND = 4'd8, OP_COUNT = 4'd9, OP_MAX = 4'd10, OP_MIN = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_REJECT = 2'd2
  } status_t;

  // signed less-than on raw words
  function automatic logic less_than(input logic [DataW-1:0] a,
                                     input logic [DataW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction
endpackage

// ----- hw/rtl/atse_cmp.sv -----
// ----------------------------------------------------------------------------
// atse_cmp
// Shared compare unit: equality and signed less-than of two words.
// ----------------------------------------------------------------------------
module atse_cmp (
  input  logic [atse_pkg::DataW-1:0] a,
  input  logic [atse_pkg::DataW-1:0] b,
  output logic                       eq,
  output logic                       lt
);
  import atse_pkg::*;
  assign eq = (a == b);
  assign lt = less_than(a, b);
endmodule

// ----- hw/rtl/array_table_sort_search_engine.sv -----
// Array table engine: one operation at a time, sequenced over a shared compare unit.
// Shift ops move elements one at a time; sort is an insertion sort doing one
// compare-and-move per step; listings give one response per element.
// Throughput: one request at a time; ready only while idle.
// Reset (rst, synchronous): fill and batch count cleared; table contents undefined.
// ----------------------------------------------------------------------------
// array_table_sort_search_engine
// Table with create/append, edit, insertion sort, search, count, max/min and listing operations.
// ----------------------------------------------------------------------------
`include "array_table_sort_search_engine_macros.svh"
module array_table_sort_search_engine #(
  parameter int unsigned CAPACITY = atse_pkg::DefCapacity
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  operation,
  input  logic [4:0]  position,
  input  logic signed [31:0] value,
  input  logic        starts_batch,
  input  logic [4:0]  batch_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic signed [31:0] element,
  output logic        found,
  output logic [4:0]  occurrences,
  output logic [4:0]  fill_count,
  output logic        last
);
  import atse_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DEL, S_INS, S_SORT_I, S_SORT_J, S_SCAN, S_BIN, S_LIST, S_OUT
  } state_t;

  state_t state;
  logic [DataW-1:0] mem [CAPACITY];
  logic [CW-1:0] fill, brem;
  logic [CW-1:0] i, j, lo, hi;   // loop indices
  logic [3:0] op;
  logic [DataW-1:0] key, cur;
  logic [4:0] cnt;
  logic fnd;

  // shared compare unit operands
  logic [DataW-1:0] ca, cb;
  logic c_eq, c_lt;
  logic [CW-1:0] mid;
  assign mid = CW'((({1'b0, lo} + {1'b0, hi}) >> 1));

  always_comb begin
    ca = key;
    cb = mem[i[IW-1:0]];
    case (state)
      S_SORT_J: begin ca = cur; cb = mem[IW'(j - 1'b1)]; end
      S_BIN:    begin ca = mem[mid[IW-1:0]]; cb = key; end
      default: ;
    endcase
  end

  atse_cmp u_cmp (.a(ca), .b(cb), .eq(c_eq), .lt(c_lt));

  assign in_ready = (state == S_IDLE);
  assign fill_count = 5'(fill);

  logic [5:0] pos6;
  assign pos6 = {1'b0, position};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; fill <= '0; brem <= '0; out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          out_valid <= 1'b0;
          if (in_valid) begin
            op <= operation; key <= value;
            status <= ST_OK; element <= '0; found <= 1'b0;
            occurrences <= '0; last <= 1'b1;
            state <= S_OUT;
            if (operation == OP_CREATE || operation == OP_APPEND) begin
              if (starts_batch) begin
                brem <= '0;
                if (operation == OP_CREATE) begin
                  fill <= '0;
                  if (batch_size != 0) begin
                    mem[0] <= value; fill <= CW'(1);
                    brem <= (6'(batch_size) > 6'(CAPACITY)) ? CW'(CAPACITY - 1)
                            : CW'(batch_size - 5'd1);
                  end
                end else if (6'(fill) >= 6'(CAPACITY) ||
                             6'(batch_size) > 6'(CAPACITY) - 6'(fill)) begin
                  status <= ST_REJECT;
                end else if (batch_size != 0) begin
                  mem[fill[IW-1:0]] <= value; fill <= fill + 1'b1;
                  brem <= CW'(batch_size - 5'd1);
                end
              end else if (brem != 0 && 6'(fill) < 6'(CAPACITY)) begin
                mem[fill[IW-1:0]] <= value; fill <= fill + 1'b1;
                brem <= brem - 1'b1;
              end else begin
                brem <= '0; status <= ST_REJECT;
              end
            end else begin
              brem <= '0;
              case (operation)
                OP_UPDATE:
                  if (position != 0 && pos6 <= 6'(fill))
                    mem[IW'(position - 5'd1)] <= value;
                  else status <= ST_REJECT;
                OP_DELETE:
                  if (position != 0 && pos6 <= 6'(fill)) begin
                    i <= CW'(position - 5'd1); state <= S_DEL;
                  end else status <= ST_REJECT;
                OP_INSERT:
                  if (6'(fill) < 6'(CAPACITY) && position != 0 &&
                      pos6 <= 6'(fill) + 6'd1) begin
                    i <= fill; j <= CW'(position); state <= S_INS;
                  end else status <= ST_REJECT;
                default:
                  if (operation > OP_MIN) status <= ST_REJECT;
                  else if (fill == 0) status <= ST_EMPTY;
                  else if (operation == OP_FIND || operation == OP_COUNT) begin
                    i <= '0; cnt <= '0; fnd <= 1'b0; state <= S_SCAN;
                  end else if (operation == OP_DISPLAY) begin
                    i <= '0; state <= S_LIST;
                  end else begin
                    i <= CW'(1); state <= S_SORT_I;
                  end
              endcase
            end
          end
        end
        S_DEL: begin
          if (6'(i) + 6'd1 < 6'(fill)) begin
            mem[i[IW-1:0]] <= mem[IW'(i + 1'b1)]; i <= i + 1'b1;
          end else begin
            fill <= fill - 1'b1; state <= S_OUT;
          end
        end
        S_INS: begin
          if (i >= j) begin
            mem[i[IW-1:0]] <= mem[IW'(i - 1'b1)]; i <= i - 1'b1;
          end else begin
            mem[IW'(j - 1'b1)] <= key; fill <= fill + 1'b1; state <= S_OUT;
          end
        end
        S_SORT_I: begin
          if (i < fill) begin
            cur <= mem[i[IW-1:0]]; j <= i; state <= S_SORT_J;
          end else begin
            case (op)
              OP_SORT: begin i <= '0; state <= S_LIST; end
              OP_SORTFIND: begin lo <= '0; hi <= fill; state <= S_BIN; end
              OP_MAX: begin element <= mem[IW'(fill - 1'b1)]; state <= S_OUT; end
              default: begin element <= mem[0]; state <= S_OUT; end
            endcase
          end
        end
        S_SORT_J: begin
          if (j != 0 && c_lt) begin
            mem[j[IW-1:0]] <= mem[IW'(j - 1'b1)]; j <= j - 1'b1;
          end else begin
            mem[j[IW-1:0]] <= cur; i <= i + 1'b1; state <= S_SORT_I;
          end
        end
        S_BIN: begin
          if (lo >= hi) begin
            found <= 1'b0; state <= S_OUT;
          end else if (c_eq) begin
            found <= 1'b1; state <= S_OUT;
          end else if (c_lt) lo <= mid + 1'b1;
          else hi <= mid;
        end
        S_SCAN: begin
          if (i < fill) begin
            if (c_eq) begin cnt <= cnt + 5'd1; fnd <= 1'b1; end
            i <= i + 1'b1;
          end else begin
            if (op == OP_FIND) found <= fnd; else occurrences <= cnt;
            state <= S_OUT;
          end
        end
        S_LIST: begin
          // one listed element per output handshake; wait for the sink
          if (!out_valid || out_ready) begin
            if (out_valid && last) begin
              out_valid <= 1'b0; state <= S_IDLE;
            end else begin
              element <= mem[i[IW-1:0]];
              last <= (i + 1'b1 == fill);
              out_valid <= 1'b1; i <= i + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (out_ready) begin out_valid <= 1'b0; state <= S_IDLE; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ATSE_ASSERT_IMP(a_fill_cap, clk, rst, 1'b1, 6'(fill) <= 6'(CAPACITY))
  `ATSE_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready)
  `ATSE_ASSERT_NXT(a_drop, clk, rst, out_valid && out_ready && last, !out_valid)
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives table requests through the engine and checks every response against
// an in-bench table predictor (or a typed row's expectation), with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module testbench;
  import atse_pkg::*;

  localparam int unsigned Cap = DefCapacity;
  localparam logic [3:0] OpBad = 4'd12;  // first unused operation code

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] element;
    logic        found;
    logic [4:0]  occurrences;
    logic [4:0]  fill_count;
    logic        last;
  } resp_t;

  typedef struct {
    logic [3:0]  op;
    logic [4:0]  pos;
    logic [31:0] val;
    logic        sb;
    logic [4:0]  bs;
    bit          typed;   // expected response typed into the row
    resp_t       rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] operation = '0;
  logic [4:0] position = '0;
  logic signed [31:0] value = '0;
  logic starts_batch = 1'b0;
  logic [4:0] batch_size = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic signed [31:0] element;
  logic found;
  logic [4:0] occurrences;
  logic [4:0] fill_count;
  logic last;

  array_table_sort_search_engine dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [31:0] tbl [Cap];
  int unsigned held = 0;
  int unsigned batch_left = 0;
  resp_t pending_resps [$];
  bit failed = 0;
  bit stim_done = 0;

  function automatic bit lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic resp_t mk(logic [1:0] st, logic [31:0] el = '0, logic fd = 0,
                               logic [4:0] oc = '0, logic lst = 1'b1);
    resp_t r;
    r.status = st; r.element = el; r.found = fd; r.occurrences = oc;
    r.fill_count = held[4:0]; r.last = lst;
    return r;
  endfunction

  function automatic void sort_tbl();
    logic [31:0] cur;
    int j;
    for (int i = 1; i < held; i++) begin
      cur = tbl[i];
      j = i;
      while (j > 0 && lt(cur, tbl[j-1])) begin
        tbl[j] = tbl[j-1];
        j--;
      end
      tbl[j] = cur;
    end
  endfunction

  function automatic void list_tbl();
    for (int i = 0; i < held; i++)
      pending_resps.push_back(mk(ST_OK, tbl[i], 0, 0, i + 1 == held));
  endfunction

  // work out the responses of one accepted request
  function automatic void predict_table_op(logic [3:0] op, logic [4:0] pos,
                                           logic [31:0] val, logic sb, logic [4:0] bs);
    logic [1:0] st;
    int unsigned n, cnt, lo, hi, mid;
    bit hit;
    st = ST_OK;
    if (op == OP_CREATE || op == OP_APPEND) begin
      if (sb) begin
        batch_left = 0;
        if (op == OP_CREATE) begin
          n = bs > Cap ? Cap : bs;
          held = 0;
          if (n > 0) begin
            tbl[0] = val; held = 1; batch_left = n - 1;
          end
        end else if (held >= Cap || bs > Cap - held) begin
          st = ST_REJECT;
        end else if (bs > 0) begin
          tbl[held] = val; held++; batch_left = bs - 1;
        end
      end else if (batch_left > 0 && held < Cap) begin
        tbl[held] = val; held++; batch_left--;
      end else begin
        batch_left = 0; st = ST_REJECT;
      end
      pending_resps.push_back(mk(st));
      return;
    end
    batch_left = 0;
    case (op)
      OP_UPDATE: begin
        if (pos >= 1 && pos <= held) tbl[pos-1] = val;
        else st = ST_REJECT;
        pending_resps.push_back(mk(st));
      end
      OP_DELETE: begin
        if (pos >= 1 && pos <= held) begin
          for (int i = pos - 1; i + 1 < held; i++) tbl[i] = tbl[i+1];
          held--;
        end else st = ST_REJECT;
        pending_resps.push_back(mk(st));
      end
      OP_INSERT: begin
        if (held < Cap && pos >= 1 && pos <= held + 1) begin
          for (int i = held; i >= pos; i--) tbl[i] = tbl[i-1];
          tbl[pos-1] = val;
          held++;
        end else st = ST_REJECT;
        pending_resps.push_back(mk(st));
      end
      default: begin
        if (op > OP_MIN) pending_resps.push_back(mk(ST_REJECT));
        else if (held == 0) pending_resps.push_back(mk(ST_EMPTY));
        else begin
          case (op)
            OP_DISPLAY: list_tbl();
            OP_SORT: begin sort_tbl(); list_tbl(); end
            OP_FIND: begin
              hit = 0;
              for (int i = 0; i < held; i++) if (tbl[i] == val) hit = 1;
              pending_resps.push_back(mk(ST_OK, '0, hit));
            end
            OP_SORTFIND: begin
              sort_tbl();
              hit = 0; lo = 0; hi = held;
              while (lo < hi && !hit) begin
                mid = (lo + hi) / 2;
                if (tbl[mid] == val) hit = 1;
                else if (lt(tbl[mid], val)) lo = mid + 1;
                else hi = mid;
              end
              pending_resps.push_back(mk(ST_OK, '0, hit));
            end
            OP_COUNT: begin
              cnt = 0;
              for (int i = 0; i < held; i++) if (tbl[i] == val) cnt++;
              pending_resps.push_back(mk(ST_OK, '0, 0, cnt[4:0]));
            end
            OP_MAX: begin sort_tbl(); pending_resps.push_back(mk(ST_OK, tbl[held-1])); end
            default: begin sort_tbl(); pending_resps.push_back(mk(ST_OK, tbl[0])); end
          endcase
        end
      end
    endcase
  endfunction

  // send one request; typed rows overwrite the predicted response
  task automatic send_request(row_t r);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= r.op; position <= r.pos; value <= r.val;
    starts_batch <= r.sb; batch_size <= r.bs;
    do @(posedge clk); while (!in_ready);
    predict_table_op(r.op, r.pos, r.val, r.sb, r.bs);
    if (r.typed) pending_resps[$] = r.rsp;
  endtask

  function automatic row_t row(logic [3:0] op, logic [4:0] pos, logic [31:0] val,
                               logic sb, logic [4:0] bs, bit typed = 0,
                               logic [1:0] st = ST_OK, logic [4:0] fc = '0);
    row_t r;
    r.op = op; r.pos = pos; r.val = val; r.sb = sb; r.bs = bs; r.typed = typed;
    r.rsp = '{status: st, element: '0, found: 0, occurrences: '0, fill_count: fc,
              last: 1'b1};
    return r;
  endfunction

  // random value: near the signed extremes, small, or fully random
  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_fffc + $urandom_range(0, 3);
      2: return $urandom_range(0, 7) - 3;
      default: return $urandom;
    endcase
  endfunction

  // ready side: random stall before every response, checked at the edge
  initial begin
    resp_t exp_r, got;
    int stall;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{status, element, found, occurrences, fill_count, last};
      if (pending_resps.size() == 0) begin
        $display("%0t: unexpected response %p", $time, got);
        failed = 1;
      end else begin
        exp_r = pending_resps.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
          failed = 1;
        end
      end
    end
  end

  initial begin
    row_t dir [$];
    int n;
    int unsigned k;
    logic [4:0] p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows; typed expectations where obvious
    dir.push_back(row(OP_DISPLAY, 0, 0, 0, 0, 1, ST_EMPTY, 0));       // empty table
    dir.push_back(row(OP_MAX, 0, 0, 0, 0, 1, ST_EMPTY, 0));
    dir.push_back(row(OP_DELETE, 1, 0, 0, 0, 1, ST_REJECT, 0));       // bad position
    dir.push_back(row(OP_APPEND, 0, 5, 0, 0, 1, ST_REJECT, 0));       // stray batch item
    dir.push_back(row(OpBad, 0, 0, 0, 0, 1, ST_REJECT, 0));           // unknown op
    dir.push_back(row(4'hf, 31, 32'hffff_ffff, 1, 31, 1, ST_REJECT, 0));
    dir.push_back(row(OP_CREATE, 0, 32'h7fff_ffff, 1, 31, 1, ST_OK, 1)); // truncated
    for (int i = 0; i < 15; i++)
      dir.push_back(row(OP_CREATE, 0, (i & 1) ? 32'h8000_0000 : i, 0, 0));
    dir.push_back(row(OP_CREATE, 0, 1, 0, 0, 1, ST_REJECT, 16));      // beyond capacity
    dir.push_back(row(OP_INSERT, 1, 0, 0, 0, 1, ST_REJECT, 16));      // full
    dir.push_back(row(OP_APPEND, 0, 0, 1, 1, 1, ST_REJECT, 16));
    foreach (dir[i]) send_request(dir[i]);

    dir.delete();
    dir.push_back(row(OP_DISPLAY, 0, 0, 0, 0));
    dir.push_back(row(OP_UPDATE, 16, 32'h8000_0000, 0, 0));
    dir.push_back(row(OP_COUNT, 0, 32'h8000_0000, 0, 0));
    dir.push_back(row(OP_FIND, 0, 4, 0, 0));
    dir.push_back(row(OP_SORTFIND, 0, 32'h7fff_ffff, 0, 0));
    dir.push_back(row(OP_SORT, 0, 0, 0, 0));
    dir.push_back(row(OP_MIN, 0, 0, 0, 0));
    dir.push_back(row(OP_DELETE, 16, 0, 0, 0));
    dir.push_back(row(OP_INSERT, 16, 9, 0, 0));
    dir.push_back(row(OP_CREATE, 0, 3, 1, 0));                         // empty create
    dir.push_back(row(OP_APPEND, 0, 7, 1, 16));                        // fills exactly
    foreach (dir[i]) send_request(dir[i]);

    // random part
    n = 0;
    while (n < 400) begin
      k = $urandom_range(0, 99);
      if (k < 20) begin
        // well-formed batch, sometimes cut short
        k = $urandom_range(0, 7) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 6);
        send_request(row(4'($urandom_range(0, 1)), 5'($urandom), rnd_val(), 1'b1,
                         5'(k)));
        n++;
        for (int i = 1; i < k && $urandom_range(0, 19) != 0; i++) begin
          send_request(row(4'($urandom_range(0, 1)), 5'($urandom), rnd_val(), 1'b0,
                           5'($urandom)));
          n++;
        end
      end else if (k < 50) begin
        p = held == 0 ? 5'd1 : 5'($urandom_range(1, held + 1));
        if ($urandom_range(0, 5) == 0) p = 5'($urandom);
        send_request(row(4'($urandom_range(OP_UPDATE, OP_INSERT)), p, rnd_val(),
                         1'($urandom), 5'($urandom)));
        n++;
      end else if (k < 95) begin
        send_request(row(4'($urandom_range(OP_DISPLAY, OP_MIN)), 5'($urandom),
                         ($urandom_range(0, 1) && held > 0) ? tbl[$urandom_range(0, held-1)]
                                                            : rnd_val(),
                         1'($urandom), 5'($urandom)));
        n++;
      end else begin
        send_request(row(4'($urandom), 5'($urandom), $urandom, 1'($urandom),
                         5'($urandom)));
        n++;
      end
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // end of run: drain, then allow for trailing latency
  initial begin
    wait (stim_done);
    while (pending_resps.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (!failed && pending_resps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
